// ===== hw/rtl/daily_temperature_statistics_top_assert.svh =====
// Assertion macros shared by the daily temperature statistics RTL.
`ifndef DAILY_TEMPERATURE_STATISTICS_TOP_ASSERT_SVH
`define DAILY_TEMPERATURE_STATISTICS_TOP_ASSERT_SVH
`ifndef SYNTHESIS
`define DTS_ASSERT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define DTS_ASSERT_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DTS_ASSERT(label, clk, rst, prop, msg)
`define DTS_ASSERT_ALWAYS(label, clk, prop, msg)
`endif
`endif

// ===== hw/rtl/dts_pkg.sv =====
// Types, codes and helper functions of the daily temperature statistics block.
package dts_pkg;

  localparam int DTS_DAY_SLOTS = 7;
  localparam int DIV_STEPS = 40;
  localparam logic [15:0] COUNT_MAX = 16'hFFFF;

  typedef enum logic [1:0] {
    OP_SAMPLE  = 2'd0,
    OP_ADVANCE = 2'd1,
    OP_RESTART = 2'd2,
    OP_QUERY   = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_EMPTY = 2'd0,
    ST_REC   = 2'd1,
    ST_DONE  = 2'd2
  } slot_status_t;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [15:0] temperature;
    logic [4:0]         hour;
    logic [5:0]         minute;
    logic [4:0]         day;
    logic [3:0]         month;
    logic [2:0]         query_slot;
  } request_t;

  typedef struct packed {
    logic [1:0]         slot_state;
    logic               has_samples;
    logic [4:0]         out_day;
    logic [3:0]         out_month;
    logic signed [15:0] min_temperature;
    logic [10:0]        min_minute_of_day;
    logic signed [15:0] avg_temperature;
    logic signed [15:0] max_temperature;
    logic [10:0]        max_minute_of_day;
    logic [2:0]         current_slot;
  } result_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [4:0]         day;
    logic [3:0]         month;
    logic signed [15:0] min_temp;
    logic [10:0]        min_time;
    logic signed [15:0] max_temp;
    logic [10:0]        max_time;
    logic signed [39:0] sum;
    logic [15:0]        count;
  } slot_entry_t;

  typedef struct packed {
    logic rd;
    logic wr;
    logic clear_all;
  } mem_ctl_t;

  function automatic slot_entry_t clear_entry(input logic [1:0] status);
    slot_entry_t e;
    e = '0;
    e.status = status;
    return e;
  endfunction

  function automatic result_t make_result(input slot_entry_t e, input logic [15:0] avg,
                                          input logic [2:0] cur);
    result_t r;
    r.slot_state        = e.status;
    r.has_samples       = (e.count != 16'd0);
    r.out_day           = e.day;
    r.out_month         = e.month;
    r.min_temperature   = e.min_temp;
    r.min_minute_of_day = e.min_time;
    r.avg_temperature   = avg;
    r.max_temperature   = e.max_temp;
    r.max_minute_of_day = e.max_time;
    r.current_slot      = cur;
    return r;
  endfunction

endpackage

// ===== hw/rtl/dts_slot_mem.sv =====
// Slot memory with one write and one registered read port and per-entry valid bits.
module dts_slot_mem #(
  parameter int DEPTH = dts_pkg::DTS_DAY_SLOTS,
  parameter int AW = $clog2(DEPTH)
) (
  input  logic                clk,
  input  logic                rst,
  input  dts_pkg::mem_ctl_t   ctl,
  input  logic [AW-1:0]       wr_addr,
  input  dts_pkg::slot_entry_t wr_data,
  input  logic [AW-1:0]       rd_addr,
  output dts_pkg::slot_entry_t rd_data
);
  import dts_pkg::*;
  `include "daily_temperature_statistics_top_assert.svh"

  slot_entry_t mem [DEPTH];
  logic [DEPTH-1:0] valid;
  slot_entry_t rd_q;
  logic rd_vld;
  logic rd_first;

  always_ff @(posedge clk) begin
    if (ctl.wr) begin
      mem[wr_addr] <= wr_data;
    end
    if (ctl.rd) begin
      rd_q     <= mem[rd_addr];
      rd_vld   <= valid[rd_addr];
      rd_first <= (rd_addr == '0);
    end
  end

  always_ff @(posedge clk) begin
    if (rst || ctl.clear_all) begin
      valid <= '0;
    end else if (ctl.wr) begin
      valid[wr_addr] <= 1'b1;
    end
  end

  // An entry never written since reset or restart reads as a cleared slot;
  // slot zero is the one being recorded after a restart.
  assign rd_data = rd_vld ? rd_q : clear_entry(rd_first ? ST_REC : ST_EMPTY);

  `DTS_ASSERT(a_no_wr_on_clear, clk, rst, (ctl.wr |-> !ctl.clear_all), "write during clear")
  `DTS_ASSERT(a_no_rd_wr_overlap, clk, rst, (!(ctl.rd && ctl.wr)), "read and write overlap")
  `DTS_ASSERT(a_wr_in_range, clk, rst, (ctl.wr |-> 32'(wr_addr) < DEPTH), "write out of range")
endmodule

// ===== hw/rtl/dts_div.sv =====
// Sequential signed division of the slot sum by the sample count, one bit per cycle.
module dts_div (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  input  logic signed [39:0] dividend,
  input  logic [15:0]        divisor,
  output logic               busy,
  output logic               done,
  output logic [15:0]        quotient
);
  import dts_pkg::*;
  `include "daily_temperature_statistics_top_assert.svh"

  localparam int CW = $clog2(DIV_STEPS + 1);

  logic [39:0] acc;
  logic [15:0] rem;
  logic [15:0] dsr;
  logic        neg;
  logic [CW-1:0] cnt;
  logic [16:0] rem_sh;
  logic [16:0] diff;
  logic        ge;

  assign rem_sh = {rem, acc[39]};
  assign diff   = rem_sh - {1'b0, dsr};
  assign ge     = (rem_sh >= {1'b0, dsr});

  always_ff @(posedge clk) begin
    if (start) begin
      neg <= dividend[39];
      acc <= dividend[39] ? 40'(-dividend) : dividend;
      rem <= '0;
      dsr <= divisor;
    end else if (busy) begin
      rem <= ge ? diff[15:0] : rem_sh[15:0];
      acc <= {acc[38:0], ge};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
        cnt  <= CW'(DIV_STEPS);
      end else if (busy) begin
        cnt <= cnt - 1'b1;
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = neg ? 16'(-acc[15:0]) : acc[15:0];

  `DTS_ASSERT(a_start_busy, clk, rst, (start |=> busy), "divider did not start")
  `DTS_ASSERT(a_done_idle, clk, rst, (done |-> !busy), "done while busy")
  `DTS_ASSERT(a_cnt_range, clk, rst, (32'(cnt) <= DIV_STEPS), "step count out of range")
endmodule

// ===== hw/rtl/daily_temperature_statistics_top.sv =====
// Top level of the daily temperature statistics block: request sequencer and result register.
// A sample, or a query of a slot that holds samples, reads its slot, then starts the 40-step
// divider that forms the average and strobes its result when the divider is done. A query of
// an empty or missing slot strobes after the slot read, an advance after the read and the
// clearing of the new slot, a restart from idle; busy is low again in the strobe cycle.
// Reset clears all slot valid bits at once: every slot reads cleared, slot 0 is recording.
module daily_temperature_statistics_top #(
  parameter int DAY_SLOTS = dts_pkg::DTS_DAY_SLOTS
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  dts_pkg::request_t request,
  output logic              busy,
  output logic              done,
  output dts_pkg::result_t  result
);
  import dts_pkg::*;
  `include "daily_temperature_statistics_top_assert.svh"

  localparam int SLOT_W = $clog2(DAY_SLOTS);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_READ = 4'b0010,
    S_ADV  = 4'b0100,
    S_DIV  = 4'b1000
  } state_t;

  state_t        state;
  request_t      req;
  logic [SLOT_W-1:0] active;
  slot_entry_t   ent;

  mem_ctl_t          mem_ctl;
  logic [SLOT_W-1:0] wr_addr;
  logic [SLOT_W-1:0] rd_addr;
  slot_entry_t       wr_data;
  slot_entry_t       rd_data;
  slot_entry_t       upd;

  logic              accept;
  logic              in_qvalid;
  logic              req_qvalid;
  logic [SLOT_W-1:0] active_next;
  logic [10:0]       tod;
  logic              div_start;
  logic signed [39:0] div_dividend;
  logic [15:0]       div_divisor;
  logic              div_busy;
  logic              div_done;
  logic [15:0]       div_quot;

  function automatic logic [10:0] request_hour_mul(input logic [4:0] h);
    return 11'(h) * 11'd60;
  endfunction

  assign busy   = (state != S_IDLE);
  assign accept = start && !busy;

  assign in_qvalid  = (32'(request.query_slot) < 32'(DAY_SLOTS));
  assign req_qvalid = (32'(req.query_slot) < 32'(DAY_SLOTS));
  assign active_next = (active == SLOT_W'(DAY_SLOTS - 1)) ? '0 : active + 1'b1;

  assign tod = 11'(request_hour_mul(req.hour)) + 11'(req.minute);

  always_comb begin
    upd       = rd_data;
    upd.day   = req.day;
    upd.month = req.month;
    if (rd_data.count == 16'd0 || req.temperature <= rd_data.min_temp) begin
      upd.min_temp = req.temperature;
      upd.min_time = tod;
    end
    if (rd_data.count == 16'd0 || req.temperature >= rd_data.max_temp) begin
      upd.max_temp = req.temperature;
      upd.max_time = tod;
    end
    if (rd_data.count != COUNT_MAX) begin
      upd.sum   = rd_data.sum + 40'(req.temperature);
      upd.count = rd_data.count + 16'd1;
    end
  end

  always_comb begin
    mem_ctl   = '0;
    rd_addr   = active;
    wr_addr   = active;
    wr_data   = upd;
    div_start = 1'b0;
    div_dividend = upd.sum;
    div_divisor  = upd.count;
    if (state == S_IDLE && accept) begin
      mem_ctl.clear_all = (request.operation == OP_RESTART);
      mem_ctl.rd        = (request.operation != OP_RESTART);
      if (request.operation == OP_QUERY) begin
        rd_addr = in_qvalid ? SLOT_W'(request.query_slot) : '0;
      end
    end
    if (state == S_READ) begin
      if (req.operation == OP_SAMPLE) begin
        mem_ctl.wr = 1'b1;
        div_start  = 1'b1;
      end else if (req.operation == OP_ADVANCE) begin
        mem_ctl.wr     = 1'b1;
        wr_data        = rd_data;
        wr_data.status = ST_DONE;
      end else if (req.operation == OP_QUERY) begin
        div_start    = req_qvalid && (rd_data.count != 16'd0);
        div_dividend = rd_data.sum;
        div_divisor  = rd_data.count;
      end
    end
    if (state == S_ADV) begin
      mem_ctl.wr = 1'b1;
      wr_data    = clear_entry(ST_REC);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state  <= S_IDLE;
      active <= '0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            req <= request;
            if (request.operation == OP_RESTART) begin
              active <= '0;
              result <= make_result(clear_entry(ST_REC), 16'd0, 3'd0);
              done   <= 1'b1;
            end else begin
              state <= S_READ;
            end
          end
        end
        S_READ: begin
          unique case (req.operation)
            OP_SAMPLE: begin
              ent   <= upd;
              state <= S_DIV;
            end
            OP_ADVANCE: begin
              active <= active_next;
              state  <= S_ADV;
            end
            OP_QUERY: begin
              ent <= rd_data;
              if (!req_qvalid) begin
                result <= make_result(clear_entry(ST_EMPTY), 16'd0, 3'(active));
                done   <= 1'b1;
                state  <= S_IDLE;
              end else if (rd_data.count == 16'd0) begin
                result <= make_result(rd_data, 16'd0, 3'(active));
                done   <= 1'b1;
                state  <= S_IDLE;
              end else begin
                state <= S_DIV;
              end
            end
            default: begin
              state <= S_IDLE;
            end
          endcase
        end
        S_ADV: begin
          result <= make_result(clear_entry(ST_REC), 16'd0, 3'(active));
          done   <= 1'b1;
          state  <= S_IDLE;
        end
        S_DIV: begin
          if (div_done) begin
            result <= make_result(ent, div_quot, 3'(active));
            done   <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  dts_slot_mem #(
    .DEPTH(DAY_SLOTS),
    .AW   (SLOT_W)
  ) u_mem (
    .clk    (clk),
    .rst    (rst),
    .ctl    (mem_ctl),
    .wr_addr(wr_addr),
    .wr_data(wr_data),
    .rd_addr(rd_addr),
    .rd_data(rd_data)
  );

  dts_div u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .busy    (div_busy),
    .done    (div_done),
    .quotient(div_quot)
  );

  `DTS_ASSERT(a_done_in_idle, clk, rst, (done |-> state == S_IDLE), "strobe outside idle")
  `DTS_ASSERT(a_active_range, clk, rst, (32'(active) < DAY_SLOTS), "active slot out of range")
  `DTS_ASSERT(a_div_while_wait, clk, rst, ((state == S_DIV && !div_done) |-> div_busy),
              "waiting on idle divider")
  `DTS_ASSERT(a_take_busy, clk, rst,
              ((accept && request.operation != OP_RESTART) |=> busy), "request not taken")
endmodule
